/* hdl/pae_pkg.sv */
package pae_pkg;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 9;
    localparam int DATA_W     = 32;
    localparam int STAT_W     = 3;
    localparam int IDX_OUT_W  = 7;
    localparam int FILL_OUT_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_SEARCH  = 3'd2,
        CMD_UPDATE  = 3'd3,
        CMD_MINMAX  = 3'd4,
        CMD_REVERSE = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Datapath step issued by the controller in one cycle
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_INS,
        STEP_DEL,
        STEP_SCAN,
        STEP_PUT,
        STEP_REV_RD_LO,
        STEP_REV_RD_HI,
        STEP_REV_WR_LO,
        STEP_REV_WR_HI
    } step_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS,
        S_INS_PUT,
        S_DEL,
        S_UPD,
        S_SRCH,
        S_MM,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_FIN
    } state_t;

    typedef struct packed {
        logic    load;
        logic    setup;
        step_t   step;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    finish;
        status_t fin_status;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic ins_ok;
        logic del_ok;
        logic upd_ok;
        logic ptr_at_tgt;
        logic ptr_lt_cnt;
        logic del_end;
        logic match;
        logic scan_end;
        logic lo_lt_hi;
    } dp_stat_t;

endpackage

/* hdl/pae_ram.sv */
module pae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/pae_ctrl.sv */
module pae_ctrl
    import pae_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output ctl_t     ctl,
    output logic     busy
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.full || !stat.ins_ok)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (stat.empty || !stat.del_ok)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DEL;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        state_next = stat.empty ? S_IDLE : S_SRCH;
                    end
                    CMD_UPDATE:
                    begin
                        if (stat.empty || !stat.upd_ok)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_UPD;
                        end
                    end
                    CMD_MINMAX:
                    begin
                        state_next = stat.empty ? S_IDLE : S_MM;
                    end
                    CMD_REVERSE:
                    begin
                        state_next = stat.empty ? S_IDLE : S_REV_RD_LO;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS:
            begin
                if (stat.ptr_at_tgt)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                state_next = S_FIN;
            end
            S_DEL:
            begin
                if (stat.del_end)
                begin
                    state_next = S_FIN;
                end
            end
            S_UPD:
            begin
                state_next = S_FIN;
            end
            S_SRCH:
            begin
                if (stat.match || !stat.ptr_lt_cnt)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MM:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REV_RD_LO:
            begin
                state_next = stat.lo_lt_hi ? S_REV_RD_HI : S_IDLE;
            end
            S_REV_RD_HI:
            begin
                state_next = S_REV_WR_LO;
            end
            S_REV_WR_LO:
            begin
                state_next = S_REV_WR_HI;
            end
            S_REV_WR_HI:
            begin
                state_next = S_REV_RD_LO;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        ctl = '{load: 1'b0, setup: 1'b0, step: STEP_NONE, cnt_inc: 1'b0,
                cnt_dec: 1'b0, finish: 1'b0, fin_status: ST_OK};
        case (state_reg)
            S_IDLE:
            begin
                ctl.load = start;
            end
            S_DECODE:
            begin
                ctl.setup = 1'b1;
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_FULL;
                        end
                        else if (!stat.ins_ok)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_BADPOS;
                        end
                    end
                    CMD_DELETE, CMD_UPDATE:
                    begin
                        if (stat.empty)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_EMPTY;
                        end
                        else if ((stat.cmd == CMD_DELETE) ? !stat.del_ok : !stat.upd_ok)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_BADPOS;
                        end
                    end
                    CMD_SEARCH, CMD_MINMAX, CMD_REVERSE:
                    begin
                        if (stat.empty)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                    end
                endcase
            end
            S_INS:
            begin
                if (!stat.ptr_at_tgt)
                begin
                    ctl.step = STEP_INS;
                end
            end
            S_INS_PUT:
            begin
                ctl.step    = STEP_PUT;
                ctl.cnt_inc = 1'b1;
            end
            S_DEL:
            begin
                if (stat.del_end)
                begin
                    ctl.cnt_dec = 1'b1;
                end
                else
                begin
                    ctl.step = STEP_DEL;
                end
            end
            S_UPD:
            begin
                ctl.step = STEP_PUT;
            end
            S_SRCH:
            begin
                if (stat.match)
                begin
                    ctl.finish = 1'b1;
                end
                else if (stat.ptr_lt_cnt)
                begin
                    ctl.step = STEP_SCAN;
                end
                else
                begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = ST_NOTFOUND;
                end
            end
            S_MM:
            begin
                if (stat.scan_end)
                begin
                    ctl.finish = 1'b1;
                end
                else if (stat.ptr_lt_cnt)
                begin
                    ctl.step = STEP_SCAN;
                end
            end
            S_REV_RD_LO:
            begin
                if (stat.lo_lt_hi)
                begin
                    ctl.step = STEP_REV_RD_LO;
                end
                else
                begin
                    ctl.finish = 1'b1;
                end
            end
            S_REV_RD_HI:
            begin
                ctl.step = STEP_REV_RD_HI;
            end
            S_REV_WR_LO:
            begin
                ctl.step = STEP_REV_WR_LO;
            end
            S_REV_WR_HI:
            begin
                ctl.step = STEP_REV_WR_HI;
            end
            S_FIN:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                ctl.finish = 1'b0;
            end
        endcase
    end

    // A finished transaction always returns the controller to idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> (state_reg == S_IDLE))
        else $error("controller not idle after finish");

    // An accepted command is decoded in the next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DECODE))
        else $error("accepted command not decoded");

endmodule

/* hdl/pae_datapath.sv */
module pae_datapath
    import pae_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [CMD_W-1:0]             cmd,
    input  logic signed [POS_W-1:0]      position,
    input  logic signed [DATA_W-1:0]     operand_value,
    input  ctl_t                         ctl,
    output dp_stat_t                     stat,
    output logic                         done,
    output logic [STAT_W-1:0]            status,
    output logic [IDX_OUT_W-1:0]         found_index,
    output logic signed [DATA_W-1:0]     max_value,
    output logic signed [DATA_W-1:0]     min_value,
    output logic [FILL_OUT_W-1:0]        fill_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // Latched command
    logic [CMD_W-1:0]        cmd_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic [DATA_W-1:0]       val_reg;

    // Fill count and walk pointers
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] ptr_next;
    logic [CW-1:0] aux_reg;
    logic [CW-1:0] aux_next;
    logic [CW-1:0] tgt_reg;

    // Read pipeline tags
    logic          wb_pend_reg;
    logic [AW-1:0] wb_addr_reg;
    logic          chk_pend_reg;
    logic [CW-1:0] chk_idx_reg;
    logic [DATA_W-1:0] save_reg;

    logic signed [DATA_W-1:0] mx_reg;
    logic signed [DATA_W-1:0] mn_reg;

    // Result registers
    logic                     done_reg;
    logic [STAT_W-1:0]        status_reg;
    logic [IDX_OUT_W-1:0]     found_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic [FILL_OUT_W-1:0]    fill_reg;

    // Memory port signals
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // Position checks
    logic          pos_neg;
    logic          pos_m1;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] chk_idx_x;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] tgt_ins;
    logic [CW-1:0] tgt_del;

    assign pos_neg   = pos_reg[POS_W-1];
    assign pos_m1    = (pos_reg == {POS_W{1'b1}});
    assign pos_x     = XW'(pos_reg[POS_W-2:0]);
    assign count_x   = XW'(count_reg);
    assign chk_idx_x = XW'(chk_idx_reg);
    assign ptr_dec   = ptr_reg - CW'(1);
    assign ptr_inc   = ptr_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign tgt_ins   = pos_m1 ? count_reg : pos_x[CW-1:0];
    assign tgt_del   = pos_m1 ? count_dec : pos_x[CW-1:0];

    // Status to the controller
    always_comb
    begin
        stat.cmd        = cmd_t'(cmd_reg);
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CW'(DEPTH));
        stat.ins_ok     = pos_m1 || (!pos_neg && (pos_x <= count_x));
        stat.del_ok     = pos_m1 || (!pos_neg && (pos_x < count_x));
        stat.upd_ok     = !pos_neg && (pos_x < count_x);
        stat.ptr_at_tgt = (ptr_reg == tgt_reg);
        stat.ptr_lt_cnt = (ptr_reg < count_reg);
        stat.del_end    = (ptr_inc == count_reg);
        stat.match      = chk_pend_reg && (mem_rdata == val_reg);
        stat.scan_end   = (ptr_reg == count_reg) && !chk_pend_reg;
        stat.lo_lt_hi   = (ptr_reg < aux_reg);
    end

    // Read side of the memory
    always_comb
    begin
        mem_re    = 1'b1;
        mem_raddr = ptr_reg[AW-1:0];
        case (ctl.step)
            STEP_INS:       mem_raddr = ptr_dec[AW-1:0];
            STEP_DEL:       mem_raddr = ptr_inc[AW-1:0];
            STEP_SCAN:      mem_raddr = ptr_reg[AW-1:0];
            STEP_REV_RD_LO: mem_raddr = ptr_reg[AW-1:0];
            STEP_REV_RD_HI: mem_raddr = aux_reg[AW-1:0];
            default:        mem_re    = 1'b0;
        endcase
    end

    // Write side: pending shift write-back, then put, then reverse writes
    always_comb
    begin
        mem_we    = 1'b1;
        mem_waddr = wb_addr_reg;
        mem_wdata = mem_rdata;
        if (!wb_pend_reg)
        begin
            case (ctl.step)
                STEP_PUT:
                begin
                    mem_waddr = tgt_reg[AW-1:0];
                    mem_wdata = val_reg;
                end
                STEP_REV_WR_LO:
                begin
                    mem_waddr = ptr_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                STEP_REV_WR_HI:
                begin
                    mem_waddr = aux_reg[AW-1:0];
                    mem_wdata = save_reg;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    pae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Advance the walk pointers
    always_comb
    begin
        ptr_next = ptr_reg;
        aux_next = aux_reg;
        if (ctl.setup)
        begin
            aux_next = count_dec;
            case (stat.cmd)
                CMD_INSERT: ptr_next = count_reg;
                CMD_DELETE: ptr_next = tgt_del;
                default:    ptr_next = '0;
            endcase
        end
        else
        begin
            case (ctl.step)
                STEP_INS:  ptr_next = ptr_dec;
                STEP_DEL:  ptr_next = ptr_inc;
                STEP_SCAN: ptr_next = ptr_inc;
                STEP_REV_WR_HI:
                begin
                    ptr_next = ptr_inc;
                    aux_next = aux_reg - CW'(1);
                end
                default:   ptr_next = ptr_reg;
            endcase
        end
    end

    // Update the fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_next = count_dec;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            wb_pend_reg  <= 1'b0;
            chk_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            wb_pend_reg  <= (ctl.step == STEP_INS) || (ctl.step == STEP_DEL);
            chk_pend_reg <= (ctl.step == STEP_SCAN);
            done_reg     <= ctl.finish;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
            val_reg <= operand_value;
        end
        if (ctl.setup)
        begin
            tgt_reg <= (stat.cmd == CMD_INSERT) ? tgt_ins :
                       (stat.cmd == CMD_DELETE) ? tgt_del : pos_x[CW-1:0];
        end
        ptr_reg     <= ptr_next;
        aux_reg     <= aux_next;
        wb_addr_reg <= ptr_reg[AW-1:0];
        chk_idx_reg <= ptr_reg;
        if (ctl.step == STEP_REV_RD_HI)
        begin
            save_reg <= mem_rdata;
        end
        // Fold each scanned word into the running extremes
        if (chk_pend_reg && (cmd_reg == CMD_MINMAX))
        begin
            if (chk_idx_reg == '0)
            begin
                mx_reg <= $signed(mem_rdata);
                mn_reg <= $signed(mem_rdata);
            end
            else
            begin
                if ($signed(mem_rdata) > mx_reg)
                begin
                    mx_reg <= $signed(mem_rdata);
                end
                if ($signed(mem_rdata) < mn_reg)
                begin
                    mn_reg <= $signed(mem_rdata);
                end
            end
        end
        // Capture the result of the transaction
        if (ctl.finish)
        begin
            status_reg <= ctl.fin_status;
            fill_reg   <= count_x[FILL_OUT_W-1:0];
            if ((cmd_reg == CMD_SEARCH) && (ctl.fin_status == ST_OK))
            begin
                found_reg <= chk_idx_x[IDX_OUT_W-1:0];
            end
            else
            begin
                found_reg <= '0;
            end
            if ((cmd_reg == CMD_MINMAX) && (ctl.fin_status == ST_OK))
            begin
                max_reg <= mx_reg;
                min_reg <= mn_reg;
            end
            else
            begin
                max_reg <= '0;
                min_reg <= '0;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign max_value   = max_reg;
    assign min_value   = min_reg;
    assign fill_count  = fill_reg;

    // A shift write-back never collides with a put or a reverse write
    a_wport_free: assert property (@(posedge clk) disable iff (!rst_n)
        wb_pend_reg |-> !((ctl.step == STEP_PUT) || (ctl.step == STEP_REV_WR_LO)
                          || (ctl.step == STEP_REV_WR_HI)))
        else $error("write port conflict");

    // The fill count never passes the array depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cnt_inc |-> (count_reg < CW'(DEPTH)))
        else $error("insert into a full array");

    // Each result strobe follows exactly one finish
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(ctl.finish))
        else $error("result strobe without finish");

endmodule

/* hdl/positional_array_engine_top.sv */
// Insert and delete shift the words between the position and the end of the array; search,
// minmax and reverse walk the filled words. With one memory port each way, every shift or scan
// moves one word a cycle; a reverse swap reads both words and then writes them back exchanged.
// busy drops as done rises, so a new command is taken in the strobe cycle; done is never held.
// rst_n clears the fill count and control state; array contents are undefined until written.
module positional_array_engine_top
    import pae_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] operand_value,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic [IDX_OUT_W-1:0]     found_index,
    output logic signed [DATA_W-1:0] max_value,
    output logic signed [DATA_W-1:0] min_value,
    output logic [FILL_OUT_W-1:0]    fill_count
);

    ctl_t     ctl;
    dp_stat_t stat;

    pae_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    pae_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .position      (position),
        .operand_value (operand_value),
        .ctl           (ctl),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .found_index   (found_index),
        .max_value     (max_value),
        .min_value     (min_value),
        .fill_count    (fill_count)
    );

endmodule
